/* hdl/dte_pkg.sv */
// Shared types, codes and tables for the DShot telemetry frame encoder.
package dte_pkg;

  typedef enum logic [2:0] {
    KIND_ERPM,
    KIND_CURR,
    KIND_VOLT,
    KIND_TEMP,
    KIND_EV_ON,
    KIND_EV_OFF
  } dte_kind_t;

  typedef struct packed {
    dte_kind_t   kind;
    logic [15:0] value;
  } dte_entry_t;

  typedef struct packed {
    logic [11:0] curr_div;
    logic [11:0] volt_div;
    logic [11:0] temp_div;
  } dte_cfg_t;

  localparam logic [1:0] REG_CURR_DIV = 2'd0;
  localparam logic [1:0] REG_VOLT_DIV = 2'd1;
  localparam logic [1:0] REG_TEMP_DIV = 2'd2;

  localparam logic [11:0] CURR_DIV_RESET = 12'd40;
  localparam logic [11:0] VOLT_DIV_RESET = 12'd200;
  localparam logic [11:0] TEMP_DIV_RESET = 12'd200;

  localparam logic [3:0] EDT_TYPE_TEMP  = 4'h2;
  localparam logic [3:0] EDT_TYPE_VOLT  = 4'h4;
  localparam logic [3:0] EDT_TYPE_CURR  = 4'h6;
  localparam logic [3:0] EDT_TYPE_EVENT = 4'hE;

  localparam logic [7:0]  EVENT_ON_VALUE  = 8'h00;
  localparam logic [7:0]  EVENT_OFF_VALUE = 8'hFF;
  localparam logic [15:0] PERIOD_STOPPED  = 16'hFFFF;

  // Reciprocal of 100 at shift 23 and of 25 at shift 21; exact for 16-bit inputs.
  localparam logic [16:0] DIV_RECIP = 17'd83887;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [4:0] GCR_MAP [16] = '{
    5'h19, 5'h1B, 5'h12, 5'h13, 5'h1D, 5'h15, 5'h16, 5'h17,
    5'h1A, 5'h09, 5'h0A, 5'h0B, 5'h1E, 5'h0D, 5'h0E, 5'h0F
  };

endpackage

/* hdl/dte_fifo.sv */
// Short queue between the request classifier and the frame builder.
module dte_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dte_pkg::dte_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output dte_pkg::dte_entry_t head_data
);
  import dte_pkg::*;

  dte_entry_t       mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW:0]    count_r;
  logic [Q_AW-1:0]  wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_nxt;
  logic [Q_AW:0]    count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/dte_front.sv */
// Request classifier: telemetry mode, interleaving and slot scheduling.
module dte_front (
  input  logic                clk,
  input  logic                rst_n,
  input  dte_pkg::dte_cfg_t   cfg,
  input  logic                accept,
  input  logic [15:0]         period_us,
  input  logic                motor_running,
  input  logic [15:0]         current_raw,
  input  logic [15:0]         voltage_raw,
  input  logic [7:0]          temperature_c,
  input  logic                edt_on_request,
  input  logic                edt_off_request,
  output dte_pkg::dte_entry_t entry
);
  import dte_pkg::*;

  logic        edt_mode_r;
  logic        last_ext_r;
  logic [15:0] curr_slots_r;
  logic [15:0] volt_slots_r;
  logic [15:0] temp_slots_r;
  logic        edt_mode_nxt;
  logic        last_ext_nxt;
  logic [15:0] curr_slots_nxt;
  logic [15:0] volt_slots_nxt;
  logic [15:0] temp_slots_nxt;
  logic [15:0] curr_inc;
  logic [15:0] volt_inc;
  logic [15:0] temp_inc;
  logic        slot;
  logic        curr_due;
  logic        volt_due;
  logic        temp_due;
  logic        ext;

  always_comb begin
    edt_mode_nxt = edt_off_request ? 1'b0 : (edt_on_request ? 1'b1 : edt_mode_r);
    slot     = edt_mode_nxt && !last_ext_r;
    curr_inc = curr_slots_r + 16'd1;
    volt_inc = volt_slots_r + 16'd1;
    temp_inc = temp_slots_r + 16'd1;
    curr_due = slot && (curr_inc >= {4'd0, cfg.curr_div});
    volt_due = slot && !curr_due && (volt_inc >= {4'd0, cfg.volt_div});
    temp_due = slot && !curr_due && !volt_due && (temp_inc >= {4'd0, cfg.temp_div});

    curr_slots_nxt = curr_slots_r;
    volt_slots_nxt = volt_slots_r;
    temp_slots_nxt = temp_slots_r;
    if (slot) begin
      curr_slots_nxt = curr_due ? 16'd0 : curr_inc;
      volt_slots_nxt = volt_due ? 16'd0 : volt_inc;
      temp_slots_nxt = temp_due ? 16'd0 : temp_inc;
    end

    ext = edt_on_request || edt_off_request || curr_due || volt_due || temp_due;
    if (ext) begin
      last_ext_nxt = 1'b1;
    end else if (edt_mode_nxt) begin
      last_ext_nxt = 1'b0;
    end else begin
      last_ext_nxt = last_ext_r;
    end

    if (edt_off_request) begin
      entry.kind  = KIND_EV_OFF;
      entry.value = '0;
    end else if (edt_on_request) begin
      entry.kind  = KIND_EV_ON;
      entry.value = '0;
    end else if (curr_due) begin
      entry.kind  = KIND_CURR;
      entry.value = current_raw;
    end else if (volt_due) begin
      entry.kind  = KIND_VOLT;
      entry.value = voltage_raw;
    end else if (temp_due) begin
      entry.kind  = KIND_TEMP;
      entry.value = {8'd0, temperature_c};
    end else begin
      entry.kind  = KIND_ERPM;
      entry.value = motor_running ? period_us : PERIOD_STOPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edt_mode_r   <= 1'b0;
      last_ext_r   <= 1'b0;
      curr_slots_r <= '0;
      volt_slots_r <= '0;
      temp_slots_r <= '0;
    end else if (accept) begin
      edt_mode_r   <= edt_mode_nxt;
      last_ext_r   <= last_ext_nxt;
      curr_slots_r <= curr_slots_nxt;
      volt_slots_r <= volt_slots_nxt;
      temp_slots_r <= temp_slots_nxt;
    end
  end

endmodule

/* hdl/dte_back.sv */
// Frame builder pipeline: scaling, payload and CRC, GCR and line coding.
module dte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  dte_pkg::dte_entry_t head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         frame_word,
  output logic [19:0]         gcr_word,
  output logic [20:0]         line_levels,
  output logic                is_extended
);
  import dte_pkg::*;

  logic        s2_valid_r;
  dte_kind_t   s2_kind_r;
  logic [15:0] s2_value_r;
  logic [32:0] s2_prod_r;
  logic        s3_valid_r;
  logic        s3_ext_r;
  logic [15:0] s3_frame_r;
  logic        out_valid_r;
  logic [15:0] out_frame_r;
  logic [19:0] out_gcr_r;
  logic [20:0] out_lines_r;
  logic        out_ext_r;

  logic        en_out;
  logic        en_s3;
  logic        en_s2;
  logic [9:0]  q_curr;
  logic [11:0] q_volt;
  logic [7:0]  sat_curr;
  logic [7:0]  sat_volt;
  logic [2:0]  sh;
  logic [8:0]  mant;
  logic [11:0] payload;
  logic        ext_c;
  logic [3:0]  crc;
  logic [19:0] gcr_c;
  logic [20:0] lines_c;

  assign en_out = !out_valid_r || out_ready;
  assign en_s3  = !s3_valid_r || en_out;
  assign en_s2  = !s2_valid_r || en_s3;
  assign pop    = head_valid && en_s2;

  always_comb begin
    q_curr   = s2_prod_r[32:23];
    q_volt   = s2_prod_r[32:21];
    sat_curr = (q_curr > 10'd255) ? 8'hFF : q_curr[7:0];
    sat_volt = (q_volt > 12'd255) ? 8'hFF : q_volt[7:0];

    if (s2_value_r[15]) begin
      sh = 3'd7;
    end else if (s2_value_r[14]) begin
      sh = 3'd6;
    end else if (s2_value_r[13]) begin
      sh = 3'd5;
    end else if (s2_value_r[12]) begin
      sh = 3'd4;
    end else if (s2_value_r[11]) begin
      sh = 3'd3;
    end else if (s2_value_r[10]) begin
      sh = 3'd2;
    end else if (s2_value_r[9]) begin
      sh = 3'd1;
    end else begin
      sh = 3'd0;
    end

    case (sh)
      3'd7:    mant = s2_value_r[15:7];
      3'd6:    mant = s2_value_r[14:6];
      3'd5:    mant = s2_value_r[13:5];
      3'd4:    mant = s2_value_r[12:4];
      3'd3:    mant = s2_value_r[11:3];
      3'd2:    mant = s2_value_r[10:2];
      3'd1:    mant = s2_value_r[9:1];
      default: mant = s2_value_r[8:0];
    endcase

    ext_c = 1'b1;
    case (s2_kind_r)
      KIND_CURR:   payload = {EDT_TYPE_CURR, sat_curr};
      KIND_VOLT:   payload = {EDT_TYPE_VOLT, sat_volt};
      KIND_TEMP:   payload = {EDT_TYPE_TEMP, s2_value_r[7:0]};
      KIND_EV_ON:  payload = {EDT_TYPE_EVENT, EVENT_ON_VALUE};
      KIND_EV_OFF: payload = {EDT_TYPE_EVENT, EVENT_OFF_VALUE};
      default: begin
        payload = {sh, mant};
        ext_c   = 1'b0;
      end
    endcase
    crc = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]);
  end

  always_comb begin
    gcr_c = {GCR_MAP[s3_frame_r[15:12]], GCR_MAP[s3_frame_r[11:8]],
             GCR_MAP[s3_frame_r[7:4]], GCR_MAP[s3_frame_r[3:0]]};
    lines_c[20] = 1'b1;
    for (int i = 0; i < 20; i++) begin
      lines_c[i] = ~(^(gcr_c & (20'hFFFFF << i)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_s2) begin
        s2_valid_r <= head_valid;
      end
      if (en_s3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (en_out) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_kind_r  <= head_data.kind;
      s2_value_r <= head_data.value;
      s2_prod_r  <= 33'(head_data.value) * 33'(DIV_RECIP);
    end
    if (en_s3 && s2_valid_r) begin
      s3_ext_r   <= ext_c;
      s3_frame_r <= {payload, crc};
    end
    if (en_out && s3_valid_r) begin
      out_frame_r <= s3_frame_r;
      out_gcr_r   <= gcr_c;
      out_lines_r <= lines_c;
      out_ext_r   <= s3_ext_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign frame_word  = out_frame_r;
  assign gcr_word    = out_gcr_r;
  assign line_levels = out_lines_r;
  assign is_extended = out_ext_r;

endmodule

/* hdl/dshot_telemetry_frame_encoder_top.sv */
// Top level of the DShot telemetry reply encoder with its configuration registers.
//
// Each transfer on the in_ channel is one telemetry request and yields exactly
// one reply frame on the out_ channel, in order. The front classifies the
// request in the cycle it is taken (mode, interleaving, slot counters) and
// writes it into a four-entry queue; the back pipeline scales the value,
// forms payload and CRC, then GCR and line codes.
// An input transfer passes through the queue and the s2, s3 and output
// registers before out_tvalid. One item can be taken every cycle while the
// queue is not full; the rate is set by the single-entry-per-cycle queue and the three-stage back pipeline.
// When the receiver holds out_tready low, the pipeline fills and then the
// queue; in_tready falls only when the queue is full.
// The cfg_ channel writes the three divisors and is always ready; it must be
// used only while no request is in flight. Reset clears the telemetry mode,
// the slot counters, the queue and the pipeline, and loads the divisors
// with 40, 200 and 200.
module dshot_telemetry_frame_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // period_us, current_raw, voltage_raw, temperature_c
  input  logic [2:0]  in_tuser,   // motor_running, edt_on_request, edt_off_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // frame_word, gcr_word, line_levels, zero fill
  output logic        out_tuser,  // is_extended
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import dte_pkg::*;

  dte_cfg_t    cfg_r;
  dte_cfg_t    cfg_nxt;
  dte_entry_t  front_entry;
  dte_entry_t  head_data;
  logic        q_full;
  logic        head_valid;
  logic        pop;
  logic        in_accept;
  logic [15:0] frame_word;
  logic [19:0] gcr_word;
  logic [20:0] line_levels;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CURR_DIV: cfg_nxt.curr_div = cfg_data;
        REG_VOLT_DIV: cfg_nxt.volt_div = cfg_data;
        REG_TEMP_DIV: cfg_nxt.temp_div = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curr_div <= CURR_DIV_RESET;
      cfg_r.volt_div <= VOLT_DIV_RESET;
      cfg_r.temp_div <= TEMP_DIV_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dte_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .accept          (in_accept),
    .period_us       (in_tdata[15:0]),
    .motor_running   (in_tuser[0]),
    .current_raw     (in_tdata[31:16]),
    .voltage_raw     (in_tdata[47:32]),
    .temperature_c   (in_tdata[55:48]),
    .edt_on_request  (in_tuser[1]),
    .edt_off_request (in_tuser[2]),
    .entry           (front_entry)
  );

  dte_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (front_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  dte_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .frame_word  (frame_word),
    .gcr_word    (gcr_word),
    .line_levels (line_levels),
    .is_extended (out_tuser)
  );

  assign out_tdata = {7'd0, line_levels, gcr_word, frame_word};

  a_crc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] ==
      ~(out_tdata[15:12] ^ out_tdata[11:8] ^ out_tdata[7:4])))
    else $error("reply CRC does not match payload");

  a_ext_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[15:12] == EDT_TYPE_TEMP || out_tdata[15:12] == EDT_TYPE_VOLT ||
       out_tdata[15:12] == EDT_TYPE_CURR || out_tdata[15:12] == EDT_TYPE_EVENT))
    else $error("extended reply carries an unknown type code");

  a_start_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[56] && (out_tdata[63:57] == 7'd0)))
    else $error("line code start level or fill bits wrong");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tready && !pop) |=> !in_tready)
    else $error("input ready rose without a queue pop");

endmodule

/* tb/tb_dshot_telemetry_frame_encoder_top.sv */
// Self-checking testbench for the DShot telemetry reply encoder with stream-side pacing.
`timescale 1ns / 1ps

module tb_dshot_telemetry_frame_encoder_top;
  import dte_pkg::*;

  typedef struct packed {
    logic [15:0] period;
    logic        running;
    logic [15:0] cur;
    logic [15:0] volt;
    logic [7:0]  temp;
    logic        on_req;
    logic        off_req;
  } telem_req_t;

  typedef struct packed {
    logic [15:0] frame;
    logic [19:0] gcr;
    logic [20:0] lines;
    logic        ext;
  } telem_reply_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_PATTERN,
    RX_TRICKLE
  } rx_pace_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 166;

  localparam logic [4:0] GCR5 [16] = '{
    5'h19, 5'h1B, 5'h12, 5'h13, 5'h1D, 5'h15, 5'h16, 5'h17,
    5'h1A, 5'h09, 5'h0A, 5'h0B, 5'h1E, 5'h0D, 5'h0E, 5'h0F
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_CURR_DIV;
  logic [11:0] cfg_data = '0;

  telem_req_t   in_item = '0;
  logic         in_accepted = 1'b0;
  telem_req_t   pending_reqs[$];
  telem_reply_t expected_replies[$];

  logic [11:0] curr_div = CURR_DIV_RESET;
  logic [11:0] volt_div = VOLT_DIV_RESET;
  logic [11:0] temp_div = TEMP_DIV_RESET;
  logic        edt_mode = 1'b0;
  logic        last_ext = 1'b0;
  logic [15:0] curr_slots = '0;
  logic [15:0] volt_slots = '0;
  logic [15:0] temp_slots = '0;

  int       mismatches = 0;
  int       cycles = 0;
  bit       send_gaps = 1'b1;
  int       gap_left = 0;
  int       burst_left = 0;
  rx_pace_t rx_pace = RX_FREE;
  int       hold_reqs = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       rx_tick = 0;

  assign in_tdata = {in_item.temp, in_item.volt, in_item.cur, in_item.period};
  assign in_tuser = {in_item.off_req, in_item.on_req, in_item.running};

  dshot_telemetry_frame_encoder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [11:0] ext_item(logic [3:0] kind, int unsigned value);
    logic [7:0] v;
    v = (value > 255) ? 8'hFF : value[7:0];
    return {kind, v};
  endfunction

  function automatic telem_reply_t encode_reply(telem_req_t r);
    telem_reply_t o;
    logic [11:0]  payload;
    logic [15:0]  per;
    logic [15:0]  mant;
    logic [3:0]   crc;
    logic         lvl;
    int           sh;
    payload = '0;
    o.ext = 1'b0;
    if (r.on_req) edt_mode = 1'b1;
    if (r.off_req) edt_mode = 1'b0;
    if (edt_mode) begin
      if (last_ext) begin
        last_ext = 1'b0;
      end else begin
        curr_slots = curr_slots + 16'd1;
        volt_slots = volt_slots + 16'd1;
        temp_slots = temp_slots + 16'd1;
        if (curr_slots >= {4'h0, curr_div}) begin
          payload = ext_item(EDT_TYPE_CURR, r.cur / 100);
          curr_slots = '0;
          o.ext = 1'b1;
        end else if (volt_slots >= {4'h0, volt_div}) begin
          payload = ext_item(EDT_TYPE_VOLT, r.volt / 25);
          volt_slots = '0;
          o.ext = 1'b1;
        end else if (temp_slots >= {4'h0, temp_div}) begin
          payload = ext_item(EDT_TYPE_TEMP, 32'(r.temp));
          temp_slots = '0;
          o.ext = 1'b1;
        end
      end
    end
    if (r.on_req) begin
      payload = ext_item(EDT_TYPE_EVENT, 32'(EVENT_ON_VALUE));
      o.ext = 1'b1;
    end
    if (r.off_req) begin
      payload = ext_item(EDT_TYPE_EVENT, 32'(EVENT_OFF_VALUE));
      o.ext = 1'b1;
    end
    if (o.ext) begin
      last_ext = 1'b1;
    end else begin
      per = r.running ? r.period : PERIOD_STOPPED;
      sh = 0;
      for (int b = 15; b >= 9; b--) begin
        if (sh == 0 && per[b]) sh = b - 8;
      end
      mant = per >> sh;
      payload = {sh[2:0], mant[8:0]};
    end
    crc = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]);
    o.frame = {payload, crc};
    o.gcr = {GCR5[o.frame[15:12]], GCR5[o.frame[11:8]], GCR5[o.frame[7:4]],
             GCR5[o.frame[3:0]]};
    lvl = 1'b1;
    o.lines[20] = 1'b1;
    for (int i = 19; i >= 0; i--) begin
      lvl = lvl ^ o.gcr[i];
      o.lines[i] = lvl;
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s at cycle %0d: got 0x%0h, expected 0x%0h",
             field, cycles, got, want);
    mismatches++;
  endtask

  // Transfers are observed here; the predictor runs on each accepted request.
  always @(posedge clk) begin
    telem_reply_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CURR_DIV: curr_div = cfg_data;
          REG_VOLT_DIV: volt_div = cfg_data;
          REG_TEMP_DIV: temp_div = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply", out_tdata[31:0], '0);
        end else begin
          want = expected_replies.pop_front();
          if (out_tdata[15:0] !== want.frame)
            report_mismatch("frame_word", 32'(out_tdata[15:0]), 32'(want.frame));
          if (out_tdata[35:16] !== want.gcr)
            report_mismatch("gcr_word", 32'(out_tdata[35:16]), 32'(want.gcr));
          if (out_tdata[56:36] !== want.lines)
            report_mismatch("line_levels", 32'(out_tdata[56:36]), 32'(want.lines));
          if (out_tuser !== want.ext)
            report_mismatch("is_extended", 32'(out_tuser), 32'(want.ext));
        end
      end
      if (in_tvalid && in_tready) expected_replies.push_back(encode_reply(in_item));
    end
    in_accepted <= in_tvalid && in_tready;
  end

  always @(negedge clk) begin
    if (!in_tvalid || in_accepted) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_item <= pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= send_gaps ? $urandom_range(1, 10) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      case (rx_pace)
        RX_FREE:    out_tready <= 1'b1;
        RX_COIN:    out_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_tready <= (rx_tick % 11) >= 4;
        default:    out_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_dshot_telemetry_frame_encoder_top NOT OK");
      $finish;
    end
  end

  function automatic telem_req_t mk_req(logic [15:0] period, logic running, logic [15:0] cur,
                                        logic [15:0] volt, logic [7:0] temp, logic on_req,
                                        logic off_req);
    telem_req_t r;
    r = '{period, running, cur, volt, temp, on_req, off_req};
    return r;
  endfunction

  function automatic telem_req_t rand_req();
    telem_req_t r;
    int         w;
    w = $urandom_range(0, 16);
    r.period = (w == 16) ? 16'($urandom) : 16'($urandom & ((32'd1 << w) - 1));
    r.running = ($urandom_range(0, 7) != 0);
    r.cur = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 26000));
    r.volt = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 6500));
    r.temp = 8'($urandom);
    r.on_req = ($urandom_range(0, 39) == 0);
    r.off_req = ($urandom_range(0, 59) == 0);
    return r;
  endfunction

  task automatic write_divisors(logic [11:0] c, logic [11:0] v, logic [11:0] t);
    logic [11:0] vals [3];
    logic [1:0]  idx [3];
    vals = '{c, v, t};
    idx = '{REG_CURR_DIV, REG_VOLT_DIV, REG_TEMP_DIV};
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Telemetry mode off: period extremes and exponent boundaries.
    pending_reqs.push_back(mk_req(16'd0, 1'b1, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd511, 1'b1, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd512, 1'b1, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd1234, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    drain();

    write_divisors(12'd3, 12'd2, 12'd1);
    pending_reqs.push_back(mk_req(16'd700, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(16'd1023, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd1024, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd2047, 1'b1, 16'd25599, 16'd6374, 8'd0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd2048, 1'b1, 16'd25600, 16'd6399, 8'd0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd4095, 1'b1, 16'd25600, 16'd6400, 8'd0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd4096, 1'b0, 16'd99, 16'd24, 8'd1, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd8191, 1'b1, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd8192, 1'b1, 16'd100, 16'd25, 8'd128, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd16384, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd32768, 1'b1, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    // Event requests back to back, including on and off together, and eRPM replies after them.
    pending_reqs.push_back(mk_req(16'd300, 1'b1, 16'd0, 16'd0, 8'd0, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(16'd300, 1'b1, 16'd0, 16'd0, 8'd0, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(16'd300, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(16'd300, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(16'd300, 1'b1, 16'd0, 16'd0, 8'd0, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(16'd300, 1'b1, 16'd0, 16'd0, 8'd0, 1'b0, 1'b1));
    pending_reqs.push_back(mk_req(16'hFFFF, 1'b0, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_divisors(12'd1, 12'd1, 12'd1);
        1: write_divisors(12'd4095, 12'd4095, 12'd4095);
        2: write_divisors(12'd2, 12'd3, 12'd5);
        3: write_divisors(12'd5, 12'd4, 12'd0);
        4: write_divisors(12'($urandom_range(1, 12)), 12'($urandom_range(1, 12)),
                          12'($urandom_range(1, 12)));
        5: write_divisors(12'd1, 12'd4095, 12'd2);
        6: write_divisors(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 64)),
                          12'($urandom_range(1, 4095)));
        default: write_divisors(CURR_DIV_RESET, VOLT_DIV_RESET, TEMP_DIV_RESET);
      endcase
      send_gaps = (ph % 2 == 0);
      case (ph % 4)
        0: rx_pace = RX_COIN;
        1: rx_pace = RX_FREE;
        2: rx_pace = RX_PATTERN;
        default: rx_pace = RX_TRICKLE;
      endcase
      if (ph == 1) hold_reqs++;
      begin
        telem_req_t r;
        r = rand_req();
        r.on_req = 1'b1;
        r.off_req = 1'b0;
        pending_reqs.push_back(r);
      end
      for (int k = 1; k < PHASE_ITEMS; k++) begin
        pending_reqs.push_back(rand_req());
        if (k == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch("replies still expected", expected_replies.size(), '0);
    if (mismatches == 0) begin
      $display("tb_dshot_telemetry_frame_encoder_top OK");
    end else begin
      $display("tb_dshot_telemetry_frame_encoder_top NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/dte_pkg.sv
hdl/dte_fifo.sv
hdl/dte_front.sv
hdl/dte_back.sv
hdl/dshot_telemetry_frame_encoder_top.sv
tb/tb_dshot_telemetry_frame_encoder_top.sv
